// ===== sv/majority_spin_flip_grid_defines.svh =====
// Assertion macros for the majority spin flip grid.
// Taken in by the top level; expects clk and rst_n in the including scope.
`ifndef MAJORITY_SPIN_FLIP_GRID_DEFINES_SVH
`define MAJORITY_SPIN_FLIP_GRID_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSFG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/msfg_pkg.sv =====
// Shared types, codes and the per-cell majority rule for the spin grid.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package msfg_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int FUNC_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [CFG_W-1:0] RESET_ROWS = 7'd64;
  localparam logic [CFG_W-1:0] RESET_COLS = 7'd64;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic start;     // set up the row sweep
    logic step;      // read one row into the window
    logic out_load;  // move result into the output register
  } msfg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep;     // request needs a row sweep
    logic last;      // current step is the final one
  } msfg_stat_t;

  // Flip when strictly more than half of the existing neighbors differ.
  function automatic logic cell_flips(
    input logic s,
    input logic nb_n, input logic nb_s, input logic nb_w, input logic nb_e,
    input logic ok_n, input logic ok_s, input logic ok_w, input logic ok_e
  );
    logic [2:0] n_cnt;
    logic [2:0] d_cnt;
    n_cnt = 3'(ok_n) + 3'(ok_s) + 3'(ok_w) + 3'(ok_e);
    d_cnt = 3'(ok_n & (nb_n ^ s)) + 3'(ok_s & (nb_s ^ s))
          + 3'(ok_w & (nb_w ^ s)) + 3'(ok_e & (nb_e ^ s));
    return d_cnt > (n_cnt >> 1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/msfg_req_if.sv =====
// Request channel of the spin grid: valid/ready plus the request fields.
// Depends on msfg_pkg.
`default_nettype none

interface msfg_req_if;
  import msfg_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic              spin_value;

  modport source (output valid, func, row, col, spin_value, input ready);
  modport sink   (input valid, func, row, col, spin_value, output ready);
endinterface

`default_nettype wire

// ===== sv/msfg_rsp_if.sv =====
// Result channel of the spin grid: valid/ready plus the result fields.
// Depends on msfg_pkg only through the shared import convention.
`default_nettype none

interface msfg_rsp_if;
  import msfg_pkg::*;

  logic valid;
  logic ready;
  logic flipped;
  logic stable;
  logic spin_now;
  logic out_of_range;

  modport source (output valid, flipped, stable, spin_now, out_of_range, input ready);
  modport sink   (input valid, flipped, stable, spin_now, out_of_range, output ready);
endinterface

`default_nettype wire

// ===== sv/majority_spin_flip_grid.sv =====
// Majority spin flip grid. Holds up to MAX_ROWS x MAX_COLS binary spins, one
// memory word per row, with a single read port and a single write port. An
// out-of-range write/update or an unknown function skips the row sweep. A
// write or update makes three row reads into a three-row window, lets the last
// row land and be evaluated, then writes back. A stability query streams every
// row in use (clamped to 1..MAX_ROWS, at most 127) through the same read port
// once. A finished result waits in the output register while the next request
// is taken; a result that is still unread when the next one is ready holds the
// block until the output register frees up. The spin memory is not cleared
// after reset; every cell must be written before it is read. Configuration may
// only be written while no request is in flight.
`default_nettype none
`include "majority_spin_flip_grid_defines.svh"

module majority_spin_flip_grid #(
  parameter int MAX_ROWS = msfg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = msfg_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  msfg_req_if.sink                            in_ch,
  msfg_rsp_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [msfg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [msfg_pkg::CFG_W-1:0]     cfg_wdata
);
  import msfg_pkg::*;

  msfg_cmd_t  cmd;
  msfg_stat_t stat;

  msfg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msfg_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_ch.func),
    .in_row           (in_ch.row),
    .in_col           (in_ch.col),
    .in_spin_value    (in_ch.spin_value),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .out_flipped      (out_ch.flipped),
    .out_stable       (out_ch.stable),
    .out_spin_now     (out_ch.spin_now),
    .out_out_of_range (out_ch.out_of_range)
  );

  `MSFG_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "request accepted while busy")
  `MSFG_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_ch.valid || out_ch.ready, "pending result overwritten")
  `MSFG_ASSERT_NOW(a_oor_clean, out_ch.valid && out_ch.out_of_range, !out_ch.flipped && !out_ch.stable && !out_ch.spin_now, "out-of-range result carries data")
  `MSFG_ASSERT_NOW(a_flip_not_stable, out_ch.valid, !(out_ch.flipped && out_ch.stable), "flip and stable both set")

endmodule

`default_nettype wire

// ===== sv/msfg_ctrl.sv =====
// Sequencer for the spin grid: handshakes, row sweep stepping, result hand-off.
// Depends on msfg_pkg for the command and status structs.
`default_nettype none

module msfg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire msfg_pkg::msfg_stat_t stat,
  output msfg_pkg::msfg_cmd_t       cmd
);
  import msfg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_DRAIN0 = 3'd3;
  localparam logic [2:0] ST_DRAIN1 = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.sweep) begin
          cmd.start = 1'b1;
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN0;
        end
      end
      // let the last row land in the window, then evaluate it
      ST_DRAIN0: state_nxt = ST_DRAIN1;
      ST_DRAIN1: state_nxt = ST_DONE;
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/msfg_dp.sv =====
// Datapath for the spin grid: config registers, spin row memory, three-row
// window, per-column majority logic and result registers. Depends on msfg_pkg.
`default_nettype none

module msfg_dp #(
  parameter int MAX_ROWS = msfg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = msfg_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire msfg_pkg::msfg_cmd_t            cmd,
  output msfg_pkg::msfg_stat_t                stat,
  input  wire logic [msfg_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [msfg_pkg::ROW_W-1:0]     in_row,
  input  wire logic [msfg_pkg::COL_W-1:0]     in_col,
  input  wire logic                           in_spin_value,
  input  wire logic                           cfg_we,
  input  wire logic [msfg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [msfg_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                                out_flipped,
  output logic                                out_stable,
  output logic                                out_spin_now,
  output logic                                out_out_of_range
);
  import msfg_pkg::*;

  // Rows reachable through the 7-bit register, bounded by the memory depth.
  localparam int ROWS_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  // Sweep position is row + 1, so it spans 0 .. ROWS_CAP + 1.
  localparam int POS_W    = $clog2(ROWS_CAP + 2);
  localparam int CMP_W    = (POS_W > CFG_W) ? POS_W : CFG_W;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int COL_CW   = $clog2(MAX_COLS + 1);

  logic [CFG_W-1:0]    rows_cfg_r, cols_cfg_r;
  logic [CMP_W-1:0]    rows_ext;
  logic [POS_W-1:0]    eff_rows;
  logic [COL_CW-1:0]   eff_cols;

  logic [FUNC_W-1:0]   func_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic                spin_r;

  logic                res_flip_r, res_stable_r, res_now_r, res_oor_r;
  logic                in_oor;

  logic [POS_W-1:0]    pos_r, end_r;
  logic                first_r;
  logic                pos_ok, step_eval;
  logic                is_query;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_r;
  logic                sh_r, ok_pend_r, eval_pend_r, eval_go_r;

  logic [MAX_COLS-1:0] win_prev_r, win_cur_r, win_next_r;
  logic                prev_ok_r, cur_ok_r, next_ok_r;

  logic [MAX_COLS-1:0] west_v, east_v, flip_v, onehot, new_word;
  logic [COL_AW-1:0]   col_idx;

  logic                out_flipped_r, out_stable_r, out_spin_now_r, out_oor_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= RESET_ROWS;
      cols_cfg_r <= RESET_COLS;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ROWS) begin
        rows_cfg_r <= cfg_wdata;
      end
      if (cfg_idx == CFG_COLS) begin
        cols_cfg_r <= cfg_wdata;
      end
    end
  end

  // Clamp the grid size into the supported range
  assign rows_ext = CMP_W'(rows_cfg_r);

  always_comb begin
    if (rows_ext == '0) begin
      eff_rows = POS_W'(1);
    end else if (rows_ext > CMP_W'(ROWS_CAP)) begin
      eff_rows = POS_W'(ROWS_CAP);
    end else begin
      eff_rows = POS_W'(rows_ext);
    end
    if (cols_cfg_r == '0) begin
      eff_cols = COL_CW'(1);
    end else if (cols_cfg_r > CFG_W'(MAX_COLS)) begin
      eff_cols = COL_CW'(MAX_COLS);
    end else begin
      eff_cols = COL_CW'(cols_cfg_r);
    end
  end

  assign in_oor = (in_func == FUNC_WRITE || in_func == FUNC_UPDATE) &&
                  ((CMP_W'(in_row) >= CMP_W'(eff_rows)) ||
                   (CFG_W'(in_col) >= CFG_W'(eff_cols)));

  assign is_query   = (func_r == FUNC_QUERY);
  assign stat.sweep = is_query ||
                      ((func_r == FUNC_WRITE || func_r == FUNC_UPDATE) && !res_oor_r);
  assign stat.last  = (pos_r == end_r);

  // A row exists when 1 <= pos <= rows in use
  assign pos_ok    = (pos_r != '0) && (pos_r <= eff_rows);
  // Scan evaluates after every step but the first; read-modify-write only at the end
  assign step_eval = is_query ? !first_r : (pos_r == end_r);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      row_r  <= in_row;
      col_r  <= in_col;
      spin_r <= in_spin_value;
    end
  end

  // Sweep position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      end_r   <= '0;
      first_r <= 1'b0;
    end else if (cmd.start) begin
      first_r <= 1'b1;
      if (is_query) begin
        pos_r <= POS_W'(1);
        end_r <= eff_rows + POS_W'(1);
      end else begin
        pos_r <= POS_W'(row_r);
        end_r <= POS_W'(row_r) + POS_W'(2);
      end
    end else if (cmd.step) begin
      pos_r   <= pos_r + POS_W'(1);
      first_r <= 1'b0;
    end
  end

  // Spin row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (eval_go_r && !is_query) begin
      mem[ROW_AW'(row_r)] <= new_word;
    end
    if (cmd.step && pos_ok) begin
      rd_data_r <= mem[ROW_AW'(pos_r - POS_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r        <= 1'b0;
      ok_pend_r   <= 1'b0;
      eval_pend_r <= 1'b0;
      eval_go_r   <= 1'b0;
    end else begin
      sh_r        <= cmd.step;
      ok_pend_r   <= pos_ok;
      eval_pend_r <= step_eval;
      eval_go_r   <= sh_r && eval_pend_r;
    end
  end

  // Three-row window; missing rows shift in as zero with their flag clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ok_r <= 1'b0;
      cur_ok_r  <= 1'b0;
      next_ok_r <= 1'b0;
    end else if (cmd.start) begin
      prev_ok_r <= 1'b0;
      cur_ok_r  <= 1'b0;
      next_ok_r <= 1'b0;
    end else if (sh_r) begin
      prev_ok_r <= cur_ok_r;
      cur_ok_r  <= next_ok_r;
      next_ok_r <= ok_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_r) begin
      win_prev_r <= win_cur_r;
      win_cur_r  <= win_next_r;
      win_next_r <= ok_pend_r ? rd_data_r : '0;
    end
  end

  // Majority rule for every column of the middle row
  assign west_v = {win_cur_r[MAX_COLS-2:0], 1'b0};
  assign east_v = {1'b0, win_cur_r[MAX_COLS-1:1]};

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      flip_v[j] = (j < int'(eff_cols)) &
                  cell_flips(win_cur_r[j], win_prev_r[j], win_next_r[j],
                             west_v[j], east_v[j],
                             prev_ok_r, next_ok_r, j != 0, (j + 1) < int'(eff_cols));
    end
  end

  assign col_idx = COL_AW'(col_r);
  assign onehot  = MAX_COLS'(1) << col_idx;

  always_comb begin
    if (func_r == FUNC_WRITE) begin
      new_word = spin_r ? (win_cur_r | onehot) : (win_cur_r & ~onehot);
    end else begin
      new_word = win_cur_r ^ (flip_v & onehot);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_flip_r   <= 1'b0;
      res_now_r    <= 1'b0;
      res_stable_r <= (in_func == FUNC_QUERY);
      res_oor_r    <= in_oor;
    end else if (eval_go_r) begin
      if (is_query) begin
        res_stable_r <= res_stable_r & ~(|flip_v);
      end else begin
        res_flip_r <= (func_r == FUNC_UPDATE) & flip_v[col_idx];
        res_now_r  <= new_word[col_idx];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flipped_r  <= res_flip_r;
      out_stable_r   <= res_stable_r;
      out_spin_now_r <= res_now_r;
      out_oor_r      <= res_oor_r;
    end
  end

  assign out_flipped      = out_flipped_r;
  assign out_stable       = out_stable_r;
  assign out_spin_now     = out_spin_now_r;
  assign out_out_of_range = out_oor_r;

endmodule

`default_nettype wire
